/* hdl/btilp_pkg.sv */
// Package with the shared types and character codes of the line parser.
`timescale 1ns / 1ps
`default_nettype none

package btilp_pkg;

  localparam int unsigned ValueW = 32;

  localparam logic [7:0] CharTab    = 8'd9;
  localparam logic [7:0] CharLf     = 8'd10;
  localparam logic [7:0] CharCr     = 8'd13;
  localparam logic [7:0] CharSpace  = 8'd32;
  localparam logic [7:0] CharPlus   = 8'd43;
  localparam logic [7:0] CharComma  = 8'd44;
  localparam logic [7:0] CharMinus  = 8'd45;
  localparam logic [7:0] CharZero   = 8'd48;
  localparam logic [7:0] CharNine   = 8'd57;
  localparam logic [7:0] CharOpen   = 8'd91;

  localparam logic [ValueW-1:0] MagCap  = 32'h8000_0000;
  localparam logic [ValueW-1:0] PosMax  = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    PhBlank  = 2'd0,
    PhSign   = 2'd1,
    PhDigits = 2'd2,
    PhDone   = 2'd3
  } phase_e;

  typedef struct packed {
    logic signed [ValueW-1:0] first_value;
    logic signed [ValueW-1:0] second_value;
    logic signed [ValueW-1:0] third_value;
  } value_set_t;

endpackage

`default_nettype wire

/* hdl/bracketed_triple_integer_line_parser_unit.sv */
// Top level of the bracketed triple integer line parser.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one received character per clock cycle and parses lines such
// as "[12, -3, +45]" into three saturated 32-bit signed values, one result per
// line feed. A line feed transfer yields its result on the output in the next cycle
// when no earlier result is waiting. Results wait in a two-entry buffer,
// and the input is stalled while both entries are occupied.
module bracketed_triple_integer_line_parser_unit
  import btilp_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [ValueW-1:0] first_value_o,
  output logic signed [ValueW-1:0] second_value_o,
  output logic signed [ValueW-1:0] third_value_o
);

  logic       take;
  logic       res_valid;
  logic       fifo_full;
  value_set_t res;
  value_set_t out_data;

  assign in_stall_o = fifo_full;
  assign take       = in_valid_i && !fifo_full;

  btilp_core #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .rx_byte_i  (rx_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  btilp_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .full_o     (fifo_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign first_value_o  = out_data.first_value;
  assign second_value_o = out_data.second_value;
  assign third_value_o  = out_data.third_value;

endmodule

`default_nettype wire

/* hdl/btilp_core.sv */
// Per-character parser state and the next-state logic for one line.
`timescale 1ns / 1ps
`default_nettype none

module btilp_core
  import btilp_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            res_valid_o,
  output value_set_t      res_o
);

  localparam int unsigned CntW = $clog2(LINE_LIMIT + 1);

  logic [1:0]        field_number_q, field_number_d;
  phase_e            field_phase_q, field_phase_d;
  logic              field_negative_q, field_negative_d;
  logic [ValueW-1:0] field_acc_q, field_acc_d;
  logic [ValueW-1:0] saved_first_q, saved_first_d;
  logic [ValueW-1:0] saved_second_q, saved_second_d;
  logic [CntW-1:0]   char_count_q, char_count_d;

  logic              is_digit;
  logic              is_blank;
  logic [3:0]        digit_val;
  logic [ValueW+3:0] acc_next;
  logic [ValueW-1:0] cur_value;

  assign is_digit  = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);
  assign is_blank  = (rx_byte_i == CharSpace) ||
                     ((rx_byte_i >= CharTab) && (rx_byte_i <= CharCr));
  assign digit_val = 4'(rx_byte_i - CharZero);
  assign acc_next  = ({4'd0, field_acc_q} << 3) + ({4'd0, field_acc_q} << 1) +
                     (ValueW + 4)'(digit_val);

  always_comb begin
    if (field_negative_q) begin
      cur_value = ValueW'(0) - field_acc_q;
    end else if (field_acc_q > PosMax) begin
      cur_value = PosMax;
    end else begin
      cur_value = field_acc_q;
    end
  end

  always_comb begin
    field_number_d   = field_number_q;
    field_phase_d    = field_phase_q;
    field_negative_d = field_negative_q;
    field_acc_d      = field_acc_q;
    saved_first_d    = saved_first_q;
    saved_second_d   = saved_second_q;
    char_count_d     = char_count_q;
    res_valid_o      = 1'b0;
    res_o            = '0;

    case (field_number_q)
      2'd0: begin
        res_o.first_value = cur_value;
      end
      2'd1: begin
        res_o.first_value  = saved_first_q;
        res_o.second_value = cur_value;
      end
      default: begin
        res_o.first_value  = saved_first_q;
        res_o.second_value = saved_second_q;
        res_o.third_value  = cur_value;
      end
    endcase

    if (take_i) begin
      if (rx_byte_i == CharLf) begin
        res_valid_o      = 1'b1;
        field_number_d   = '0;
        field_phase_d    = PhBlank;
        field_negative_d = 1'b0;
        field_acc_d      = '0;
        saved_first_d    = '0;
        saved_second_d   = '0;
        char_count_d     = '0;
      end else if (char_count_q < CntW'(LINE_LIMIT)) begin
        char_count_d = char_count_q + CntW'(1);
        if (field_number_q != 2'd3) begin
          if (rx_byte_i == CharComma) begin
            case (field_number_q)
              2'd0: begin
                saved_first_d    = cur_value;
                field_phase_d    = PhBlank;
                field_negative_d = 1'b0;
                field_acc_d      = '0;
              end
              2'd1: begin
                saved_second_d   = cur_value;
                field_phase_d    = PhBlank;
                field_negative_d = 1'b0;
                field_acc_d      = '0;
              end
              default: begin
                field_phase_d = PhDone;
              end
            endcase
            field_number_d = field_number_q + 2'd1;
          end else if (!((field_number_q == 2'd0) && (rx_byte_i == CharOpen))) begin
            if (field_phase_q != PhDone) begin
              if (is_digit) begin
                if (acc_next > {4'd0, MagCap}) begin
                  field_acc_d = MagCap;
                end else begin
                  field_acc_d = acc_next[ValueW-1:0];
                end
                field_phase_d = PhDigits;
              end else if ((field_phase_q == PhBlank) && is_blank) begin
                field_phase_d = PhBlank;
              end else if ((field_phase_q == PhBlank) &&
                           ((rx_byte_i == CharPlus) || (rx_byte_i == CharMinus))) begin
                field_negative_d = (rx_byte_i == CharMinus);
                field_phase_d    = PhSign;
              end else begin
                field_phase_d = PhDone;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_number_q   <= '0;
      field_phase_q    <= PhBlank;
      field_negative_q <= 1'b0;
      field_acc_q      <= '0;
      saved_first_q    <= '0;
      saved_second_q   <= '0;
      char_count_q     <= '0;
    end else begin
      field_number_q   <= field_number_d;
      field_phase_q    <= field_phase_d;
      field_negative_q <= field_negative_d;
      field_acc_q      <= field_acc_d;
      saved_first_q    <= saved_first_d;
      saved_second_q   <= saved_second_d;
      char_count_q     <= char_count_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/btilp_out_fifo.sv */
// Two-entry result buffer between the parser and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module btilp_out_fifo
  import btilp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  value_set_t      push_data_i,
  output logic            full_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output value_set_t      out_data_o
);

  logic [1:0] count_q, count_d;
  value_set_t slot0_q, slot0_d;
  value_set_t slot1_q, slot1_d;
  logic       pop;

  assign pop         = (count_q != 2'd0) && !out_stall_i;
  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot0_q;

  always_comb begin
    count_d = count_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop && push_i) begin
      if (count_q == 2'd1) begin
        slot0_d = push_data_i;
      end else begin
        slot0_d = slot1_q;
        slot1_d = push_data_i;
      end
    end else if (pop) begin
      slot0_d = slot1_q;
      count_d = count_q - 2'd1;
    end else if (push_i) begin
      if (count_q == 2'd0) begin
        slot0_d = push_data_i;
      end else begin
        slot1_d = push_data_i;
      end
      count_d = count_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

`default_nettype wire
